FILE: hw/rtl/ocp_pkg.sv
package ocp_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int AtanLen = 24;

  localparam int TwoPiQ12 = 25736;
  localparam int ElevMin = 410;
  localparam int ElevMax = 12458;
  localparam int ElevReset = 6434;
  localparam int RadiusMin = 41;
  localparam int RadiusMax = 16777215;
  localparam int RadiusReset = 40960;

  localparam logic signed [35:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] GainQ30 = 36'sd652032874;

  typedef enum logic [1:0] {
    REG_FOCUS_X = 2'd0,
    REG_FOCUS_Y = 2'd1,
    REG_FOCUS_Z = 2'd2
  } reg_idx_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;       // apply deltas to the state
    logic cor_start;  // start CORDIC for one angle
    logic cor_sel;    // 0: elevation, 1: azimuth
    logic cor_step;   // one CORDIC iteration
    logic save_elev;  // latch sin/cos of elevation
    logic save_azim;  // latch sin/cos of azimuth
    logic [2:0] mul_op;  // product sequencing step
    logic out_load;
  } ocp_cmd_t;

  typedef struct packed {
    logic cor_done;
  } ocp_sts_t;

  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] t;
    case (i)
      0: t = 36'sd843314856;
      1: t = 36'sd497837829;
      2: t = 36'sd263043836;
      3: t = 36'sd133525158;
      4: t = 36'sd67021686;
      5: t = 36'sd33543515;
      6: t = 36'sd16775850;
      7: t = 36'sd8388437;
      8: t = 36'sd4194282;
      9: t = 36'sd2097149;
      10: t = 36'sd1048575;
      11: t = 36'sd524287;
      12: t = 36'sd262143;
      13: t = 36'sd131071;
      14: t = 36'sd65535;
      15: t = 36'sd32767;
      16: t = 36'sd16383;
      17: t = 36'sd8191;
      18: t = 36'sd4095;
      19: t = 36'sd2047;
      20: t = 36'sd1023;
      21: t = 36'sd511;
      22: t = 36'sd255;
      23: t = 36'sd127;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/ocp_ctrl.sv
module ocp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  ocp_pkg::ocp_sts_t sts,
  output logic busy,
  output ocp_pkg::ocp_cmd_t cmd
);
  import ocp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_COR0 = 8'b00000010,
    S_RUN0 = 8'b00000100,
    S_COR1 = 8'b00001000,
    S_RUN1 = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_WAIT = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [2:0] mstep, mstep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= '0;
    end else begin
      state <= state_next;
      mstep <= mstep_next;
    end
  end

  always_comb begin
    state_next = state;
    mstep_next = mstep;
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_COR0;
        end
      end
      S_COR0: begin
        cmd.cor_start = 1'b1;
        state_next = S_RUN0;
      end
      S_RUN0: begin
        if (sts.cor_done) begin
          cmd.save_elev = 1'b1;
          state_next = S_COR1;
        end else begin
          cmd.cor_step = 1'b1;
        end
      end
      S_COR1: begin
        cmd.cor_start = 1'b1;
        cmd.cor_sel = 1'b1;
        state_next = S_RUN1;
      end
      S_RUN1: begin
        cmd.cor_sel = 1'b1;
        if (sts.cor_done) begin
          cmd.save_azim = 1'b1;
          mstep_next = '0;
          state_next = S_MUL;
        end else begin
          cmd.cor_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_op = mstep;
        mstep_next = mstep + 3'd1;
        if (mstep == 3'd3) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hw/rtl/ocp_dp.sv
module ocp_dp #(
  parameter int CORDIC_STEPS = ocp_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst,
  input  ocp_pkg::ocp_cmd_t cmd,
  output ocp_pkg::ocp_sts_t sts,
  input  logic signed [15:0] d_theta,
  input  logic signed [15:0] d_phi,
  input  logic signed [23:0] d_rho,
  input  logic signed [23:0] focus_x,
  input  logic signed [23:0] focus_y,
  input  logic signed [23:0] focus_z,
  output logic signed [25:0] pos_x,
  output logic signed [25:0] pos_y,
  output logic signed [25:0] pos_z
);
  import ocp_pkg::*;

  localparam int Steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
  localparam int StepW = $clog2(Steps + 1);

  logic [13:0] elevation;
  logic [14:0] azimuth;
  logic [23:0] radius;

  // State update. Azimuth sum lies in (-2T, 3T), so wrap is a few compares.
  logic signed [16:0] e_sum;
  logic signed [16:0] p_sum;
  logic signed [25:0] r_sum;
  logic [14:0] p_wrap;

  always_comb begin
    e_sum = $signed({3'b000, elevation}) + 17'(d_theta);
    if (e_sum < 17'(ElevMin)) e_sum = 17'(ElevMin);
    if (e_sum > 17'(ElevMax)) e_sum = 17'(ElevMax);
    p_sum = $signed({2'b00, azimuth}) + 17'(d_phi);
    if (p_sum > 0) begin
      if (p_sum >= 17'(2 * TwoPiQ12)) p_wrap = 15'(p_sum - 17'(2 * TwoPiQ12));
      else if (p_sum >= 17'(TwoPiQ12)) p_wrap = 15'(p_sum - 17'(TwoPiQ12));
      else p_wrap = 15'(p_sum);
    end else begin
      if (p_sum <= -17'(TwoPiQ12)) p_wrap = 15'(p_sum + 17'(2 * TwoPiQ12));
      else p_wrap = 15'(p_sum + 17'(TwoPiQ12));
    end
    r_sum = $signed({2'b00, radius}) + 26'(d_rho);
    if (r_sum < 26'(RadiusMin)) r_sum = 26'(RadiusMin);
    if (r_sum > 26'(RadiusMax)) r_sum = 26'(RadiusMax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elevation <= 14'(ElevReset);
      azimuth <= '0;
      radius <= 24'(RadiusReset);
    end else if (cmd.load) begin
      elevation <= e_sum[13:0];
      azimuth <= p_wrap;
      radius <= r_sum[23:0];
    end
  end

  // Shared CORDIC, one iteration a cycle.
  logic signed [35:0] cx, cy, cz;
  logic cneg;
  logic [StepW-1:0] ci;
  logic signed [35:0] z0, z1;
  logic n0, n1;
  logic signed [35:0] xs, ys;

  always_comb begin
    z0 = cmd.cor_sel ? 36'($signed({1'b0, azimuth})) <<< 18
                     : 36'($signed({1'b0, elevation})) <<< 18;
    n0 = 1'b0;
    if (z0 > HalfPiQ30) begin
      z0 = z0 - PiQ30;
      n0 = 1'b1;
    end
    z1 = z0;
    n1 = n0;
    if (z0 > HalfPiQ30) begin
      z1 = z0 - PiQ30;
      n1 = ~n0;
    end
    xs = cx >>> ci;
    ys = cy >>> ci;
  end

  assign sts.cor_done = (ci == StepW'(Steps));

  always_ff @(posedge clk) begin
    if (cmd.cor_start) begin
      cx <= GainQ30;
      cy <= '0;
      cz <= z1;
      cneg <= n1;
      ci <= '0;
    end else if (cmd.cor_step) begin
      if (!cz[35]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_q30(int'(ci));
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_q30(int'(ci));
      end
      ci <= ci + StepW'(1);
    end
  end

  function automatic logic signed [15:0] to_q15(input logic signed [35:0] v);
    logic signed [36:0] r;
    r = (37'(v) + 37'sd16384) >>> 15;
    if (r > 37'sd32767) r = 37'sd32767;
    if (r < -37'sd32768) r = -37'sd32768;
    return r[15:0];
  endfunction

  logic signed [35:0] fx, fy;
  logic signed [15:0] se, ce, sa, ca;
  always_comb begin
    fx = cneg ? -cx : cx;
    fy = cneg ? -cy : cy;
  end

  always_ff @(posedge clk) begin
    if (cmd.save_elev) begin
      se <= to_q15(fy);
      ce <= to_q15(fx);
    end
    if (cmd.save_azim) begin
      sa <= to_q15(fy);
      ca <= to_q15(fx);
    end
  end

  // One multiply per step: r*se, r*ce, rs*sa, rs*ca.
  logic signed [40:0] rs, rc, pxp, pzp;
  logic signed [24:0] ma;
  logic signed [40:0] mb;
  logic signed [15:0] mc;
  logic signed [56:0] prod;
  logic signed [40:0] pr2;

  always_comb begin
    ma = $signed({1'b0, radius});
    mc = (cmd.mul_op == 3'd0) ? se : ce;
    mb = (cmd.mul_op == 3'd2) ? rs : rs;
    prod = 57'(mb) * 57'(cmd.mul_op == 3'd2 ? sa : ca);
    pr2 = 41'(ma) * 41'(mc);
  end

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      3'd0: if (!cmd.save_azim) rs <= pr2;
      3'd1: rc <= pr2;
      3'd2: pxp <= 41'((prod + 57'sd536870912) >>> 30);
      3'd3: pzp <= 41'((-prod + 57'sd536870912) >>> 30);
      default: ;
    endcase
    if (cmd.out_load) begin
      pos_x <= 26'(41'(focus_x) + pxp);
      pos_y <= 26'(41'(focus_y) + ((rc + 41'sd16384) >>> 15));
      pos_z <= 26'(41'(focus_z) + pzp);
    end
  end
endmodule

FILE: hw/rtl/orbit_camera_position_unit.sv
// Channel | Dir | Beat contents
// s_axis  | in  | tdata: d_theta[15:0], d_phi[31:16], d_rho[55:32]
// m_axis  | out | tdata: pos_x[25:0], pos_y[51:26], pos_z[77:52], zero pad to 80
// cfg     | in  | cfg_index selects focus_x/y/z, cfg_data 24 bit
// Each item goes through the state update, runs the shared CORDIC once for elevation
// and once for azimuth, then the multiply steps, and waits for the output register to
// be free before its result is loaded; the CORDIC runs set most of the processing time.
// A new input beat is taken only when the block is idle; the result sits in an output
// register, and the next item runs while it waits, then stalls until it is taken.
// Reset is synchronous; it restores the elevation, azimuth and radius and clears the focus.
module orbit_camera_position_unit #(
  parameter int CORDIC_STEPS = ocp_pkg::CordicStepsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // d_theta, d_phi, d_rho
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [79:0] m_axis_tdata,  // pos_x, pos_y, pos_z, zero pad
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import ocp_pkg::*;

  ocp_cmd_t cmd;
  ocp_sts_t sts;
  logic busy;
  logic signed [23:0] focus_x, focus_y, focus_z;
  logic signed [25:0] pos_x, pos_y, pos_z;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      focus_x <= '0;
      focus_y <= '0;
      focus_z <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FOCUS_X: focus_x <= cfg_data;
        REG_FOCUS_Y: focus_y <= cfg_data;
        REG_FOCUS_Z: focus_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  assign m_axis_tdata = {2'b00, pos_z, pos_y, pos_x};

  ocp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .sts(sts), .busy(busy), .cmd(cmd)
  );

  ocp_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .d_theta(s_axis_tdata[15:0]), .d_phi(s_axis_tdata[31:16]),
    .d_rho(s_axis_tdata[55:32]),
    .focus_x(focus_x), .focus_y(focus_y), .focus_z(focus_z),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
  );
endmodule

FILE: hw/rtl/ocp_checker.sv
module ocp_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [79:0] m_axis_tdata
);
  // An accepted input never yields a result on the very next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");
  // The block is busy right after taking a beat.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accept");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[79:78] == 2'b00)
    else $error("pad bits set");
endmodule

bind orbit_camera_position_unit ocp_checker u_chk (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
